// ===== hdl/sse_pkg.sv =====
// shared types and constants of the 2d spring stretch element kernel
// no dependencies; sse_outq and the kernel refer to it by scoped names
package sse_pkg;

   // quotient bits kept by every divider; the widest in-range quotient
   // (stiffness terms) stays below 2^48
   localparam int unsigned QUOT_W = 49;
   // root width of the length units; squared edge length is below 2^67
   localparam int unsigned LEN_W = 34;
   localparam int unsigned SQ_W = 67;

   // edge geometry carried alongside the square root units
   typedef struct packed {
      logic [32:0] ax;
      logic [32:0] ay;
      logic [65:0] ax2;
      logic [65:0] ay2;
      logic [65:0] axay;
      logic [66:0] s;
      logic [31:0] k;
      logic        sx;
      logic        sy;
   } geo_type;

   // operands carried alongside the wide multipliers
   typedef struct packed {
      logic [65:0] den;
      logic [31:0] l0;
      logic [31:0] k;
      logic        dneg;
      logic        degen;
      logic        sx;
      logic        sy;
   } mid_type;

   // sign and special-case flags carried alongside the dividers
   typedef struct packed {
      logic dneg;
      logic degen;
      logic sx;
      logic sy;
   } flag_type;

   // one result item
   typedef struct packed {
      logic signed [31:0] force_first_x;
      logic signed [31:0] force_first_y;
      logic signed [31:0] stiff_xx;
      logic signed [31:0] stiff_xy;
      logic signed [31:0] stiff_yy;
      logic [31:0]        energy;
      logic               degenerate;
   } rsp_type;

endpackage

// ===== hdl/sse_req_if.sv =====
// input channel of the spring element kernel: valid/ready and one element
// no dependencies
interface sse_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] disp_first_x;
   logic signed [31:0] disp_first_y;
   logic signed [31:0] disp_second_x;
   logic signed [31:0] disp_second_y;
   logic signed [31:0] rest_edge_x;
   logic signed [31:0] rest_edge_y;

   modport source (
      output valid, disp_first_x, disp_first_y, disp_second_x, disp_second_y,
             rest_edge_x, rest_edge_y,
      input  ready
   );
   modport sink (
      input  valid, disp_first_x, disp_first_y, disp_second_x, disp_second_y,
             rest_edge_x, rest_edge_y,
      output ready
   );
endinterface

// ===== hdl/sse_rsp_if.sv =====
// result channel of the spring element kernel: valid/ready and one result
// no dependencies
interface sse_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] force_first_x;
   logic signed [31:0] force_first_y;
   logic signed [31:0] stiff_xx;
   logic signed [31:0] stiff_xy;
   logic signed [31:0] stiff_yy;
   logic [31:0]        energy;
   logic               degenerate;

   modport source (
      output valid, force_first_x, force_first_y, stiff_xx, stiff_xy, stiff_yy,
             energy, degenerate,
      input  ready
   );
   modport sink (
      input  valid, force_first_x, force_first_y, stiff_xx, stiff_xy, stiff_yy,
             energy, degenerate,
      output ready
   );
endinterface

// ===== hdl/sse_delay.sv =====
// delay line with a valid bit per stage, advanced by the pipeline enable
// no dependencies
module sse_delay #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             ce,
   input  logic             in_valid,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   output logic [WIDTH-1:0] out_data
);

   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] data_ff [DEPTH];

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ce) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < DEPTH; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // payload taps
   always_ff @(posedge clock) begin
      if (ce) begin
         data_ff[0] <= in_data;
         for (int i = 1; i < DEPTH; i++) begin
            data_ff[i] <= data_ff[i-1];
         end
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign out_data  = data_ff[DEPTH-1];

endmodule

// ===== hdl/sse_sqrt.sv =====
// pipelined integer square root, one root bit per stage (floor result)
// no dependencies
module sse_sqrt #(
   parameter int unsigned IN_W  = 67,
   parameter int unsigned OUT_W = 34
) (
   input  logic             clock,
   input  logic             ce,
   input  logic [IN_W-1:0]  radicand,
   output logic [OUT_W-1:0] root
);

   localparam int unsigned W = 2 * OUT_W + 1;

   logic [IN_W-1:0]  rem_ff  [OUT_W];
   logic [OUT_W-1:0] root_ff [OUT_W];

   for (genvar i = 0; i < OUT_W; i++) begin : g_step
      localparam int unsigned B = OUT_W - 1 - i;
      logic [IN_W-1:0]  rem_prev;
      logic [OUT_W-1:0] root_prev;
      logic [W-1:0]     trial;

      if (i == 0) begin : g_first
         assign rem_prev  = radicand;
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[i-1];
         assign root_prev = root_ff[i-1];
      end

      // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
      assign trial = (W'(root_prev) << (B + 1)) + (W'(1) << (2 * B));

      always_ff @(posedge clock) begin
         if (ce) begin
            if (W'(rem_prev) >= trial) begin
               rem_ff[i]  <= rem_prev - trial[IN_W-1:0];
               root_ff[i] <= root_prev | (OUT_W'(1) << B);
            end else begin
               rem_ff[i]  <= rem_prev;
               root_ff[i] <= root_prev;
            end
         end
      end
   end

   assign root = root_ff[OUT_W-1];

endmodule

// ===== hdl/sse_wmul.sv =====
// wide unsigned multiplier split into two partial products over two stages
// no dependencies
module sse_wmul #(
   parameter int unsigned A_W = 66,
   parameter int unsigned B_W = 32
) (
   input  logic                 clock,
   input  logic                 ce,
   input  logic [A_W-1:0]       a,
   input  logic [B_W-1:0]       b,
   output logic [A_W+B_W-1:0]   prod
);

   localparam int unsigned LO_W = A_W / 2;
   localparam int unsigned HI_W = A_W - LO_W;
   localparam int unsigned P_W  = A_W + B_W;

   logic [LO_W+B_W-1:0] pp_lo_ff;
   logic [HI_W+B_W-1:0] pp_hi_ff;
   logic [P_W-1:0]      prod_ff;

   // partial products, then their aligned sum
   always_ff @(posedge clock) begin
      if (ce) begin
         pp_lo_ff <= (LO_W+B_W)'(a[LO_W-1:0]) * (LO_W+B_W)'(b);
         pp_hi_ff <= (HI_W+B_W)'(a[A_W-1:LO_W]) * (HI_W+B_W)'(b);
         prod_ff  <= (P_W'(pp_hi_ff) << LO_W) + P_W'(pp_lo_ff);
      end
   end

   assign prod = prod_ff;

endmodule

// ===== hdl/sse_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with an
// overflow flag when the quotient does not fit Q_W bits; no dependencies
module sse_div #(
   parameter int unsigned NUM_W = 99,
   parameter int unsigned DEN_W = 66,
   parameter int unsigned Q_W   = 49
) (
   input  logic             clock,
   input  logic             ce,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [Q_W-1:0]   quot,
   output logic             ovf
);

   localparam int unsigned CMP_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

   logic [NUM_W-1:0] rem_ff  [Q_W];
   logic [DEN_W-1:0] den_ff  [Q_W];
   logic [Q_W-1:0]   quot_ff [Q_W+1];
   logic             ovf_ff  [Q_W+1];

   // entry stage: range check of the whole quotient
   always_ff @(posedge clock) begin
      if (ce) begin
         rem_ff[0]  <= num;
         den_ff[0]  <= den;
         quot_ff[0] <= '0;
         ovf_ff[0]  <= CMP_W'(num) >= (CMP_W'(den) << Q_W);
      end
   end

   // one trial subtraction per stage, highest quotient bit first
   for (genvar i = 1; i <= Q_W; i++) begin : g_step
      localparam int unsigned B = Q_W - i;
      logic [CMP_W-1:0] trial;
      logic             take;

      assign trial = CMP_W'(den_ff[i-1]) << B;
      assign take  = CMP_W'(rem_ff[i-1]) >= trial;

      always_ff @(posedge clock) begin
         if (ce) begin
            quot_ff[i] <= take ? (quot_ff[i-1] | (Q_W'(1) << B)) : quot_ff[i-1];
            ovf_ff[i]  <= ovf_ff[i-1];
         end
      end

      if (i < Q_W) begin : g_carry
         always_ff @(posedge clock) begin
            if (ce) begin
               rem_ff[i] <= take ? rem_ff[i-1] - trial[NUM_W-1:0] : rem_ff[i-1];
               den_ff[i] <= den_ff[i-1];
            end
         end
      end
   end

   assign quot = quot_ff[Q_W];
   assign ovf  = ovf_ff[Q_W];

endmodule

// ===== hdl/sse_outq.sv =====
// two-entry result queue between the pipeline and the result channel
// depends on sse_pkg and sse_rsp_if
module sse_outq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sse_pkg::rsp_type  push_data,
   output logic              space,
   sse_rsp_if.source         rsp_if
);

   sse_pkg::rsp_type entry_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic             pop;
   sse_pkg::rsp_type head;

   assign pop      = rsp_if.valid && rsp_if.ready;
   assign count_in = count_ff + 2'(push) - 2'(pop);
   assign space    = (count_ff != 2'd2);

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // head item onto the channel
   assign head                 = entry_ff[rd_ptr_ff];
   assign rsp_if.valid         = (count_ff != 2'd0);
   assign rsp_if.force_first_x = head.force_first_x;
   assign rsp_if.force_first_y = head.force_first_y;
   assign rsp_if.stiff_xx      = head.stiff_xx;
   assign rsp_if.stiff_xy      = head.stiff_xy;
   assign rsp_if.stiff_yy      = head.stiff_yy;
   assign rsp_if.energy        = head.energy;
   assign rsp_if.degenerate    = head.degenerate;

endmodule

// ===== hdl/spring_stretch_element_kernel.sv =====
// spring stretch element kernel: one item in, one result out, one item per cycle
// while the result queue has room. the pipeline depth is set mostly by the two
// 34-stage square roots and the 50-stage dividers (one bit per stage).
// the two-entry result queue lets items enter while a result waits.
// synchronous active-high reset empties the pipeline and sets stiffness to 1.0.
// depends on sse_pkg, sse_req_if, sse_rsp_if, sse_delay, sse_sqrt, sse_wmul, sse_div, sse_outq
module spring_stretch_element_kernel (
   input  logic        clock,
   input  logic        reset,
   sse_req_if.sink     req_if,
   sse_rsp_if.source   rsp_if,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   localparam int unsigned QW = sse_pkg::QUOT_W;

   // stiffness register
   logic [31:0] stiffness_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stiffness_ff <= 32'h0001_0000;
      end else if (csr_wr_en) begin
         stiffness_ff <= csr_wr_data;
      end
   end

   // global advance: the whole pipeline moves while the queue has room
   logic ce;
   logic space;
   assign ce           = space;
   assign req_if.ready = ce;

   // stage a: current edge
   logic               valid_a_ff;
   logic signed [33:0] lx_a_ff, ly_a_ff;
   logic signed [31:0] rx_a_ff, ry_a_ff;
   logic [31:0]        k_a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (ce) begin
         valid_a_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         lx_a_ff <= 34'(req_if.rest_edge_x) + 34'(req_if.disp_second_x)
                    - 34'(req_if.disp_first_x);
         ly_a_ff <= 34'(req_if.rest_edge_y) + 34'(req_if.disp_second_y)
                    - 34'(req_if.disp_first_y);
         rx_a_ff <= req_if.rest_edge_x;
         ry_a_ff <= req_if.rest_edge_y;
         k_a_ff  <= stiffness_ff;
      end
   end

   // stage b: magnitudes and signs
   logic        valid_b_ff;
   logic [32:0] ax_b_ff, ay_b_ff;
   logic [31:0] bx_b_ff, by_b_ff;
   logic        sx_b_ff, sy_b_ff;
   logic [31:0] k_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else if (ce) begin
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         ax_b_ff <= 33'(lx_a_ff[33] ? -lx_a_ff : lx_a_ff);
         ay_b_ff <= 33'(ly_a_ff[33] ? -ly_a_ff : ly_a_ff);
         bx_b_ff <= 32'(rx_a_ff[31] ? -rx_a_ff : rx_a_ff);
         by_b_ff <= 32'(ry_a_ff[31] ? -ry_a_ff : ry_a_ff);
         sx_b_ff <= lx_a_ff[33];
         sy_b_ff <= ly_a_ff[33];
         k_b_ff  <= k_a_ff;
      end
   end

   // stage c: squares and cross product
   logic        valid_c_ff;
   logic [32:0] ax_c_ff, ay_c_ff;
   logic [65:0] ax2_c_ff, ay2_c_ff, axay_c_ff;
   logic [63:0] bx2_c_ff, by2_c_ff;
   logic        sx_c_ff, sy_c_ff;
   logic [31:0] k_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_c_ff <= 1'b0;
      end else if (ce) begin
         valid_c_ff <= valid_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         ax2_c_ff  <= 66'(ax_b_ff) * 66'(ax_b_ff);
         ay2_c_ff  <= 66'(ay_b_ff) * 66'(ay_b_ff);
         axay_c_ff <= 66'(ax_b_ff) * 66'(ay_b_ff);
         bx2_c_ff  <= 64'(bx_b_ff) * 64'(bx_b_ff);
         by2_c_ff  <= 64'(by_b_ff) * 64'(by_b_ff);
         ax_c_ff   <= ax_b_ff;
         ay_c_ff   <= ay_b_ff;
         sx_c_ff   <= sx_b_ff;
         sy_c_ff   <= sy_b_ff;
         k_c_ff    <= k_b_ff;
      end
   end

   // stage d: squared lengths
   logic              valid_d_ff;
   sse_pkg::geo_type  geo_d_ff;
   logic [63:0]       s0_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_d_ff <= 1'b0;
      end else if (ce) begin
         valid_d_ff <= valid_c_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         geo_d_ff.s    <= 67'(ax2_c_ff) + 67'(ay2_c_ff);
         geo_d_ff.ax   <= ax_c_ff;
         geo_d_ff.ay   <= ay_c_ff;
         geo_d_ff.ax2  <= ax2_c_ff;
         geo_d_ff.ay2  <= ay2_c_ff;
         geo_d_ff.axay <= axay_c_ff;
         geo_d_ff.k    <= k_c_ff;
         geo_d_ff.sx   <= sx_c_ff;
         geo_d_ff.sy   <= sy_c_ff;
         s0_d_ff       <= bx2_c_ff + by2_c_ff;
      end
   end

   // lengths: current and rest
   logic [sse_pkg::LEN_W-1:0] l_e, l0_wide_e;
   logic                      valid_e;
   sse_pkg::geo_type          geo_e;

   sse_sqrt #(.IN_W(sse_pkg::SQ_W), .OUT_W(sse_pkg::LEN_W)) u_sqrt_cur (
      .clock    (clock),
      .ce       (ce),
      .radicand (geo_d_ff.s),
      .root     (l_e)
   );

   sse_sqrt #(.IN_W(sse_pkg::SQ_W), .OUT_W(sse_pkg::LEN_W)) u_sqrt_rest (
      .clock    (clock),
      .ce       (ce),
      .radicand (sse_pkg::SQ_W'(s0_d_ff)),
      .root     (l0_wide_e)
   );

   sse_delay #(.WIDTH($bits(sse_pkg::geo_type)), .DEPTH(sse_pkg::LEN_W)) u_geo_dly (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (valid_d_ff),
      .in_data   (geo_d_ff),
      .out_valid (valid_e),
      .out_data  (geo_e)
   );

   // stage p1: length change and zero-length check
   logic             valid_p1_ff;
   sse_pkg::geo_type geo_p1_ff;
   logic [33:0]      l_p1_ff, dm_p1_ff;
   logic [31:0]      l0_p1_ff;
   logic             dneg_p1_ff, degen_p1_ff;
   logic [31:0]      l0_e;
   logic             dneg_e;

   assign l0_e   = l0_wide_e[31:0];
   assign dneg_e = l_e < 34'(l0_e);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_p1_ff <= 1'b0;
      end else if (ce) begin
         valid_p1_ff <= valid_e;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         geo_p1_ff   <= geo_e;
         l_p1_ff     <= l_e;
         l0_p1_ff    <= l0_e;
         dneg_p1_ff  <= dneg_e;
         dm_p1_ff    <= dneg_e ? 34'(l0_e) - l_e : l_e - 34'(l0_e);
         degen_p1_ff <= (l_e == '0) || (l0_e == '0);
      end
   end

   // stage p2: narrow products
   logic             valid_p2_ff;
   sse_pkg::geo_type geo_p2_ff;
   logic [33:0]      l_p2_ff;
   logic [65:0]      kd_p2_ff;
   logic [67:0]      dm2_p2_ff;
   sse_pkg::mid_type mid_p2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_p2_ff <= 1'b0;
      end else if (ce) begin
         valid_p2_ff <= valid_p1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         kd_p2_ff        <= 66'(geo_p1_ff.k) * 66'(dm_p1_ff);
         dm2_p2_ff       <= 68'(dm_p1_ff) * 68'(dm_p1_ff);
         mid_p2_ff.den   <= 66'(l0_p1_ff) * 66'(l_p1_ff);
         mid_p2_ff.l0    <= l0_p1_ff;
         mid_p2_ff.k     <= geo_p1_ff.k;
         mid_p2_ff.dneg  <= dneg_p1_ff;
         mid_p2_ff.degen <= degen_p1_ff;
         mid_p2_ff.sx    <= geo_p1_ff.sx;
         mid_p2_ff.sy    <= geo_p1_ff.sy;
         geo_p2_ff       <= geo_p1_ff;
         l_p2_ff         <= l_p1_ff;
      end
   end

   // p3..p4: wide products for the numerators and the stiffness divisor
   logic [98:0]  n_fx, n_fy;
   logic [99:0]  n_en;
   logic [100:0] d_ls;
   logic [97:0]  n_txx, n_tyy, n_txy;

   sse_wmul #(.A_W(66), .B_W(33)) u_mul_fx (
      .clock(clock), .ce(ce), .a(kd_p2_ff), .b(geo_p2_ff.ax), .prod(n_fx)
   );
   sse_wmul #(.A_W(66), .B_W(33)) u_mul_fy (
      .clock(clock), .ce(ce), .a(kd_p2_ff), .b(geo_p2_ff.ay), .prod(n_fy)
   );
   sse_wmul #(.A_W(68), .B_W(32)) u_mul_en (
      .clock(clock), .ce(ce), .a(dm2_p2_ff), .b(geo_p2_ff.k), .prod(n_en)
   );
   sse_wmul #(.A_W(67), .B_W(34)) u_mul_ls (
      .clock(clock), .ce(ce), .a(geo_p2_ff.s), .b(l_p2_ff), .prod(d_ls)
   );
   sse_wmul #(.A_W(66), .B_W(32)) u_mul_txx (
      .clock(clock), .ce(ce), .a(geo_p2_ff.ay2), .b(geo_p2_ff.k), .prod(n_txx)
   );
   sse_wmul #(.A_W(66), .B_W(32)) u_mul_tyy (
      .clock(clock), .ce(ce), .a(geo_p2_ff.ax2), .b(geo_p2_ff.k), .prod(n_tyy)
   );
   sse_wmul #(.A_W(66), .B_W(32)) u_mul_txy (
      .clock(clock), .ce(ce), .a(geo_p2_ff.axay), .b(geo_p2_ff.k), .prod(n_txy)
   );

   logic             valid_p4;
   sse_pkg::mid_type mid_p4;

   sse_delay #(.WIDTH($bits(sse_pkg::mid_type)), .DEPTH(2)) u_mid_dly (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (valid_p2_ff),
      .in_data   (mid_p2_ff),
      .out_valid (valid_p4),
      .out_data  (mid_p4)
   );

   // dividers
   logic [QW-1:0] q_fx, q_fy, q_txx, q_tyy, q_txy, q_k0, q_en;
   logic          o_fx, o_fy, o_txx, o_tyy, o_txy, o_k0, o_en;

   sse_div #(.NUM_W(99), .DEN_W(66), .Q_W(QW)) u_div_fx (
      .clock(clock), .ce(ce), .num(n_fx), .den(mid_p4.den), .quot(q_fx), .ovf(o_fx)
   );
   sse_div #(.NUM_W(99), .DEN_W(66), .Q_W(QW)) u_div_fy (
      .clock(clock), .ce(ce), .num(n_fy), .den(mid_p4.den), .quot(q_fy), .ovf(o_fy)
   );
   sse_div #(.NUM_W(114), .DEN_W(101), .Q_W(QW)) u_div_txx (
      .clock(clock), .ce(ce), .num({n_txx, 16'h0000}), .den(d_ls),
      .quot(q_txx), .ovf(o_txx)
   );
   sse_div #(.NUM_W(114), .DEN_W(101), .Q_W(QW)) u_div_tyy (
      .clock(clock), .ce(ce), .num({n_tyy, 16'h0000}), .den(d_ls),
      .quot(q_tyy), .ovf(o_tyy)
   );
   sse_div #(.NUM_W(114), .DEN_W(101), .Q_W(QW)) u_div_txy (
      .clock(clock), .ce(ce), .num({n_txy, 16'h0000}), .den(d_ls),
      .quot(q_txy), .ovf(o_txy)
   );
   sse_div #(.NUM_W(48), .DEN_W(32), .Q_W(QW)) u_div_k0 (
      .clock(clock), .ce(ce), .num({mid_p4.k, 16'h0000}), .den(mid_p4.l0),
      .quot(q_k0), .ovf(o_k0)
   );
   sse_div #(.NUM_W(100), .DEN_W(49), .Q_W(QW)) u_div_en (
      .clock(clock), .ce(ce), .num(n_en), .den({mid_p4.l0, 17'h00000}),
      .quot(q_en), .ovf(o_en)
   );

   logic              valid_z;
   sse_pkg::flag_type flag_p4, flag_z;

   assign flag_p4.dneg  = mid_p4.dneg;
   assign flag_p4.degen = mid_p4.degen;
   assign flag_p4.sx    = mid_p4.sx;
   assign flag_p4.sy    = mid_p4.sy;

   sse_delay #(.WIDTH($bits(sse_pkg::flag_type)), .DEPTH(QW + 1)) u_flag_dly (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (valid_p4),
      .in_data   (flag_p4),
      .out_valid (valid_z),
      .out_data  (flag_z)
   );

   // saturate a quotient magnitude with a sign to signed 32 bits
   function automatic logic [31:0] sat_mag(input logic [QW-1:0] q, input logic ovf,
                                           input logic neg);
      logic [QW-1:0] limit;
      logic [31:0]   m;
      limit = neg ? QW'(33'h0_8000_0000) : QW'(33'h0_7FFF_FFFF);
      m     = (ovf || (q > limit)) ? limit[31:0] : q[31:0];
      return neg ? (32'h0 - m) : m;
   endfunction

   // saturate a signed difference to signed 32 bits
   function automatic logic [31:0] sat_diff(input logic [QW-1:0] a, input logic [QW-1:0] b);
      logic signed [QW:0] d;
      d = $signed({1'b0, a}) - $signed({1'b0, b});
      if (d > $signed((QW + 1)'(33'h0_7FFF_FFFF))) begin
         return 32'h7FFF_FFFF;
      end else if (d < -$signed((QW + 1)'(33'h0_8000_0000))) begin
         return 32'h8000_0000;
      end
      return d[31:0];
   endfunction

   // result assembly
   sse_pkg::rsp_type res;
   logic             push;

   always_comb begin
      res = '0;
      if (flag_z.degen) begin
         res.degenerate = 1'b1;
      end else begin
         res.force_first_x = sat_mag(q_fx, o_fx, flag_z.dneg != flag_z.sx);
         res.force_first_y = sat_mag(q_fy, o_fy, flag_z.dneg != flag_z.sy);
         res.stiff_xy      = sat_mag(q_txy, o_txy, flag_z.sx == flag_z.sy);
         res.stiff_xx      = (o_txx || o_k0) ? 32'h8000_0000 : sat_diff(q_txx, q_k0);
         res.stiff_yy      = (o_tyy || o_k0) ? 32'h8000_0000 : sat_diff(q_tyy, q_k0);
         res.energy        = (o_en || (q_en[QW-1:32] != '0)) ? 32'hFFFF_FFFF
                                                              : q_en[31:0];
      end
   end

   assign push = valid_z && ce;

   sse_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (res),
      .space     (space),
      .rsp_if    (rsp_if)
   );

endmodule
